// ===== rtl/top_k_score_keeper_defines.svh =====
// ----------------------------------------------------------------------------
// Top-k score keeper assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef TOP_K_SCORE_KEEPER_DEFINES_SVH
`define TOP_K_SCORE_KEEPER_DEFINES_SVH

// implication checked every clock outside reset
`define TKS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define TKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tks_pkg.sv =====
// ----------------------------------------------------------------------------
// Top-k score keeper package
// Sizes, result kinds and the controller-datapath command types.
// ----------------------------------------------------------------------------
package tks_pkg;

	localparam int MaxEntries = 32;
	localparam int IdxW = $clog2(MaxEntries);
	localparam int CntW = $clog2(MaxEntries + 1);
	localparam int KeyW = 64;
	localparam int ScoreW = 32;
	localparam int RowW = 40;

	typedef enum logic [2:0] {
		KIND_INSERTED = 3'd0,
		KIND_REPLACED = 3'd1,
		KIND_REJECTED = 3'd2,
		KIND_DUMP = 3'd3,
		KIND_EMPTY = 3'd4
	} kind_t;

	typedef struct packed {
		logic [KeyW-1:0] key;
		logic signed [ScoreW-1:0] score;
		logic [RowW-1:0] row;
	} entry_t;

	typedef struct packed {
		logic load;      // capture input item
		logic insert;    // sorted insert, count up
		logic replace;   // drop minimum then sorted insert
		logic dump_clr;  // clear dump pointer
		logic dump_adv;  // advance dump pointer
	} dp_cmd_t;

	typedef struct packed {
		logic [CntW-1:0] count;
		logic full;
		logic beats;        // new score beats stored minimum
		logic dump_last;    // pointer on last stored entry
		entry_t head;       // entry under dump pointer
		entry_t minimum;
	} dp_status_t;

endpackage

// ===== rtl/tks_datapath.sv =====
// ----------------------------------------------------------------------------
// Top-k score keeper datapath
// Sorted register chain, item register, count and dump pointer.
// ----------------------------------------------------------------------------
module tks_datapath (
	input  logic clk,
	input  logic arst_n,
	input  logic [5:0] capacity_q,
	input  logic op_in,
	input  tks_pkg::entry_t item_in,
	input  tks_pkg::dp_cmd_t cmd,
	output logic item_op,
	output tks_pkg::dp_status_t status
);

	tks_pkg::entry_t cells_q [tks_pkg::MaxEntries];
	tks_pkg::entry_t item_q;
	logic op_q;
	logic [tks_pkg::CntW-1:0] count_q;
	logic [tks_pkg::IdxW-1:0] ptr_q;
	logic [tks_pkg::MaxEntries-1:0] gt;
	logic [tks_pkg::CntW-1:0] cap_eff;

	function automatic logic less(input tks_pkg::entry_t a, input tks_pkg::entry_t b);
		if (a.score != b.score) begin
			return a.score < b.score;
		end
		if (a.row != b.row) begin
			return a.row < b.row;
		end
		return a.key < b.key;
	endfunction

	always_comb begin
		if (capacity_q == 6'd0) begin
			cap_eff = tks_pkg::CntW'(1);
		end else if (32'(capacity_q) > tks_pkg::MaxEntries) begin
			cap_eff = tks_pkg::CntW'(tks_pkg::MaxEntries);
		end else begin
			cap_eff = tks_pkg::CntW'(capacity_q);
		end
	end

	// gt[i]: stored cell i orders after the new item
	always_comb begin
		for (int i = 0; i < tks_pkg::MaxEntries; i++) begin
			gt[i] = less(item_q, cells_q[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item_in;
			op_q <= op_in;
		end
		if (cmd.insert) begin
			for (int i = 0; i < tks_pkg::MaxEntries; i++) begin
				if (32'(i) < 32'(count_q) && gt[i]) begin
					if (i + 1 < tks_pkg::MaxEntries) begin
						cells_q[(i + 1) % tks_pkg::MaxEntries] <= cells_q[i];
					end
				end
				if (32'(i) == 32'(count_q) || (32'(i) < 32'(count_q) && gt[i])) begin
					if (i == 0 || !gt[(i + tks_pkg::MaxEntries - 1) % tks_pkg::MaxEntries]
							|| 32'(i) > 32'(count_q)) begin
						cells_q[i] <= item_q;
					end
				end
			end
		end else if (cmd.replace) begin
			for (int i = 0; i < tks_pkg::MaxEntries; i++) begin
				if (32'(i) < 32'(count_q)) begin
					if (i + 1 < tks_pkg::MaxEntries && 32'(i + 1) < 32'(count_q)
							&& !gt[(i + 1) % tks_pkg::MaxEntries]) begin
						cells_q[i] <= cells_q[(i + 1) % tks_pkg::MaxEntries];
					end else if (i == 0 || !gt[i]) begin
						cells_q[i] <= item_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q <= '0;
		end else begin
			if (cmd.insert) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.dump_clr) begin
				ptr_q <= '0;
			end else if (cmd.dump_adv) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	assign item_op = op_q;
	assign status.count = count_q;
	assign status.full = count_q >= cap_eff;
	assign status.beats = item_q.score > cells_q[0].score;
	assign status.dump_last = (tks_pkg::CntW'(ptr_q) + 1'b1) == count_q;
	assign status.head = cells_q[ptr_q];
	assign status.minimum = cells_q[0];

endmodule

// ===== rtl/tks_ctrl.sv =====
// ----------------------------------------------------------------------------
// Top-k score keeper controller
// Sequences insert, replace and dump, and drives the output register.
// ----------------------------------------------------------------------------
module tks_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  logic item_op,
	input  tks_pkg::dp_status_t status,
	output tks_pkg::dp_cmd_t cmd,
	output logic [2:0] kind,
	output logic [63:0] out_key,
	output logic signed [31:0] out_score,
	output logic [39:0] out_row,
	output logic [5:0] fill,
	output logic last
);

	typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_DUMP} state_t;
	state_t state_q;
	logic out_free;
	logic out_load;

	assign out_free = !out_valid || out_ready;
	assign in_ready = state_q == S_IDLE;
	assign out_load = out_free && (state_q == S_DUMP
			|| (state_q == S_DECIDE && !(item_op && status.count != '0)));

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && state_q == S_IDLE;
		unique case (state_q)
			S_IDLE: cmd.dump_clr = 1'b1;
			S_DECIDE: begin
				if (out_free && !item_op) begin
					cmd.insert = !status.full;
					cmd.replace = status.full && status.beats;
				end
			end
			S_DUMP: cmd.dump_adv = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (out_free) begin
						if (item_op && status.count != '0) begin
							state_q <= S_DUMP;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_DUMP: begin
					if (out_free && status.dump_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == S_DECIDE && out_free) begin
			out_key <= '0;
			out_score <= '0;
			out_row <= '0;
			last <= 1'b1;
			fill <= 6'(status.count);
			if (item_op) begin
				kind <= tks_pkg::KIND_EMPTY;
			end else if (!status.full) begin
				kind <= tks_pkg::KIND_INSERTED;
				fill <= 6'(status.count + 1'b1);
			end else if (status.beats) begin
				kind <= tks_pkg::KIND_REPLACED;
				out_key <= status.minimum.key;
				out_score <= status.minimum.score;
				out_row <= status.minimum.row;
			end else begin
				kind <= tks_pkg::KIND_REJECTED;
			end
		end else if (state_q == S_DUMP && out_free) begin
			kind <= tks_pkg::KIND_DUMP;
			out_key <= status.head.key;
			out_score <= status.head.score;
			out_row <= status.head.row;
			fill <= 6'(status.count);
			last <= status.dump_last;
		end
	end

endmodule

// ===== rtl/top_k_score_keeper.sv =====
// ----------------------------------------------------------------------------
// Top-k score keeper
// Keeps up to capacity best entries sorted by score, row and key.
// ----------------------------------------------------------------------------
// An insert first captures the item, then compares it against every
// stored cell at once and shifts the sorted chain. A dump also captures
// the request first, then reads each stored entry in turn as a result
// from the chain under a walking pointer. A stalled result that still
// holds the output register holds up both.
// Write capacity only while idle.
module top_k_score_keeper (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [5:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic operation,
	input  logic [63:0] key,
	input  logic signed [31:0] score,
	input  logic [39:0] row,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] kind,
	output logic [63:0] out_key,
	output logic signed [31:0] out_score,
	output logic [39:0] out_row,
	output logic [5:0] fill,
	output logic last
);

	logic [5:0] capacity_q;
	tks_pkg::entry_t item;
	tks_pkg::dp_cmd_t cmd;
	tks_pkg::dp_status_t status;
	logic item_op;

	assign cfg_ready = 1'b1;
	assign item.key = key;
	assign item.score = score;
	assign item.row = row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 6'd32;
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	tks_datapath u_dp (
		.clk, .arst_n, .capacity_q, .op_in(operation), .item_in(item),
		.cmd, .item_op, .status
	);

	tks_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.item_op, .status, .cmd, .kind, .out_key, .out_score, .out_row,
		.fill, .last
	);

endmodule

// ===== rtl/tks_checker.sv =====
// ----------------------------------------------------------------------------
// Top-k score keeper port checker
// Watches result kinds, fill bounds and the input and output handshakes.
// ----------------------------------------------------------------------------
`include "top_k_score_keeper_defines.svh"

module tks_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [2:0] kind,
	input logic [5:0] fill,
	input logic last
);

	`TKS_ASSERT_IMPL(a_kind, clk, arst_n, out_valid, kind <= tks_pkg::KIND_EMPTY, "bad kind")
	`TKS_ASSERT_IMPL(a_fill, clk, arst_n, out_valid, fill <= 6'(tks_pkg::MaxEntries), "fill")
	`TKS_ASSERT_IMPL(a_single, clk, arst_n, out_valid && kind != tks_pkg::KIND_DUMP, last, "last")
	`TKS_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(kind), "hold")
	`TKS_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready, "busy")

endmodule

bind top_k_score_keeper tks_checker u_tks_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .kind, .fill, .last
);
